>>> design/nak_retransmit_scheduler_assert.svh
// Assertion macros for the NAK retransmit scheduler.
// Used by nak_retransmit_scheduler.sv; the including module provides i_clk and i_rst_n.
`ifndef NAK_RETRANSMIT_SCHEDULER_ASSERT_SVH
`define NAK_RETRANSMIT_SCHEDULER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define NRS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define NRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/nrs_pkg.sv
// Shared types and codes for the NAK retransmit scheduler.
// No dependencies; imported by the top level.
package nrs_pkg;

    // Result codes carried on the output tuser.
    typedef enum logic [2:0] {
        KIND_DELAYED    = 3'd0,
        KIND_RESEND     = 3'd1,
        KIND_SUPPRESSED = 3'd2,
        KIND_INVALID    = 3'd3,
        KIND_OVERFLOW   = 3'd4,
        KIND_SUMMARY    = 3'd5
    } t_kind;

    // Input operation codes.
    localparam logic OP_NAK  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DELAY    = 3'd0;
    localparam logic [2:0] CFG_LINGER   = 3'd1;
    localparam logic [2:0] CFG_GROUP    = 3'd2;
    localparam logic [2:0] CFG_ACTIVE   = 3'd3;
    localparam logic [2:0] CFG_TERM_LEN = 3'd4;

    // One slot table entry. Activity lives in flip-flops, not here.
    typedef struct packed {
        logic        linger;
        logic [31:0] term;
        logic [31:0] offset;
        logic [30:0] length;
        logic [62:0] expiry;
    } t_slot_entry;

    localparam int ENTRY_W = $bits(t_slot_entry);

endpackage

>>> design/nrs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module nrs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/nak_retransmit_scheduler.sv
// NAK retransmit scheduler: slot table in a RAM, scanned one slot per cycle while no tick
// resend waits on the output register. A NAK scans the slots in use and then loads its final
// result; a tick scans them and then loads its summary. An invalid NAK skips the scan, and so
// does a tick with no busy slot. A new item is taken only when the block is back in idle, after
// the last item has loaded its final result. Synchronous active-low reset clears slot activity
// and the busy count and loads register defaults.
`include "nak_retransmit_scheduler_assert.svh"

module nak_retransmit_scheduler #(
    parameter int MAX_SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port.
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [39:0]  i_cfg_data,
    // Input items.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: nak_term[31:0], nak_offset[63:32], nak_length[94:64], now_time[156:95], zero
    input  logic [159:0] s_axis_tdata,
    // tuser: operation
    input  logic         s_axis_tuser,
    // Result items.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: resend_term[31:0], resend_offset[63:32], resend_length[94:64],
    //        changed_count[100:95], zero
    output logic [103:0] m_axis_tdata,
    // tuser: result_kind
    output nrs_pkg::t_kind m_axis_tuser,
    // tlast: last
    output logic         m_axis_tlast
);

    import nrs_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_SUM
    } t_state;

    // Configuration registers.
    logic [39:0] r_delay;
    logic [39:0] r_linger;
    logic        r_group;
    logic [5:0]  r_active;
    logic [30:0] r_tlen;

    // Control and item registers.
    t_state          r_state;
    logic            r_op;
    logic [31:0]     r_term;
    logic [31:0]     r_off;
    logic [30:0]     r_len;
    logic [61:0]     r_now;
    logic            r_invalid;
    logic            r_supp;
    logic            r_pick_ok;
    logic [AW-1:0]   r_pick;
    logic [CW-1:0]   r_rd_idx;
    logic            r_ev_valid;
    logic [AW-1:0]   r_ev_idx;
    logic [5:0]      r_changed;
    logic [5:0]      r_busy;
    logic [MAX_SLOTS-1:0] r_valid;

    // Output register.
    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [31:0] r_out_term;
    logic [31:0] r_out_off;
    logic [30:0] r_out_len;
    logic [5:0]  r_out_cnt;
    logic        r_out_last;

    // RAM interface.
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    t_slot_entry        wr_entry;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    t_slot_entry        rd_entry;

    logic [CW-1:0] slots_used;
    logic          in_accept;
    logic          in_invalid;
    logic          out_free;
    logic          out_load;
    logic          adv;
    logic          rd_issue;
    logic          scan_done;
    logic          ev_active;
    logic          ev_expired;
    logic          ev_match;
    logic          ev_tick_resend;
    logic          ev_tick_free;
    logic          tick_wr;
    logic          fin_write;
    logic          fin_immediate;
    t_kind         fin_kind;
    logic signed [33:0] slot_end;
    logic signed [33:0] nak_pos;

    // Configuration writes are taken at any time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= '0;
            r_linger <= '0;
            r_group  <= 1'b0;
            r_active <= 6'd1;
            r_tlen   <= 31'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DELAY:    r_delay  <= i_cfg_data;
                CFG_LINGER:   r_linger <= i_cfg_data;
                CFG_GROUP:    r_group  <= i_cfg_data[0];
                CFG_ACTIVE:   r_active <= i_cfg_data[5:0];
                CFG_TERM_LEN: r_tlen   <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // Number of slots scanned: one in unicast mode, else the clamped register.
    always_comb begin
        if (!r_group || r_active == 6'd0) begin
            slots_used = CW'(1);
        end else if ({1'b0, r_active} > 7'(MAX_SLOTS)) begin
            slots_used = CW'(MAX_SLOTS);
        end else begin
            slots_used = CW'(r_active);
        end
    end

    // Offset range check of an arriving NAK.
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign in_invalid = s_axis_tdata[63] ||
                        (({2'b0, s_axis_tdata[62:32]} + 33'd32) > {2'b0, r_tlen});

    // Evaluation of the slot entry returned by the RAM.
    assign rd_entry   = t_slot_entry'(ram_rdata);
    assign ev_active  = r_valid[r_ev_idx];
    assign ev_expired = {1'b0, r_now} > rd_entry.expiry;
    assign slot_end   = $signed({{2{rd_entry.offset[31]}}, rd_entry.offset})
                      + $signed({3'b0, rd_entry.length});
    assign nak_pos    = $signed({{2{r_off[31]}}, r_off});
    assign ev_match   = (rd_entry.term == r_term) &&
                        ($signed(rd_entry.offset) <= $signed(r_off)) &&
                        (nak_pos < slot_end);
    assign ev_tick_resend = (r_op == OP_TICK) && ev_active && !rd_entry.linger && ev_expired;
    assign ev_tick_free   = (r_op == OP_TICK) && ev_active && rd_entry.linger && ev_expired;

    // Scan pipeline advances unless a tick resend waits for the output register.
    assign out_free  = !r_out_valid || m_axis_tready;
    assign adv       = !(r_ev_valid && ev_tick_resend && !out_free);
    assign rd_issue  = (r_state == S_SCAN) && adv && (r_rd_idx < slots_used);
    assign ram_re    = rd_issue;
    assign scan_done = (r_state == S_SCAN) && !r_ev_valid && (r_rd_idx >= slots_used);

    // Final result of a NAK.
    assign fin_immediate = (r_delay == 40'd0);
    always_comb begin
        if (r_invalid) begin
            fin_kind = KIND_INVALID;
        end else if (r_supp) begin
            fin_kind = KIND_SUPPRESSED;
        end else if (!r_pick_ok) begin
            fin_kind = KIND_OVERFLOW;
        end else if (fin_immediate) begin
            fin_kind = KIND_RESEND;
        end else begin
            fin_kind = KIND_DELAYED;
        end
    end

    // Slot writes: a new NAK at the end of its scan, or a tick resend during the scan.
    assign fin_write = (r_state == S_FIN) && out_free && !r_invalid && !r_supp && r_pick_ok;
    assign tick_wr   = (r_state == S_SCAN) && r_ev_valid && ev_tick_resend && out_free;
    assign ram_we    = fin_write || tick_wr;
    assign ram_waddr = fin_write ? r_pick : r_ev_idx;

    // A new result enters the output register in this cycle.
    assign out_load  = tick_wr || (((r_state == S_FIN) || (r_state == S_SUM)) && out_free);

    always_comb begin
        if (fin_write) begin
            wr_entry.linger = fin_immediate;
            wr_entry.term   = r_term;
            wr_entry.offset = r_off;
            wr_entry.length = r_len;
            wr_entry.expiry = 63'(r_now) + (fin_immediate ? 63'(r_linger) : 63'(r_delay));
        end else begin
            wr_entry.linger = 1'b1;
            wr_entry.term   = rd_entry.term;
            wr_entry.offset = rd_entry.offset;
            wr_entry.length = rd_entry.length;
            wr_entry.expiry = 63'(r_now) + 63'(r_linger);
        end
    end

    nrs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS),
        .ADDR_W(AW)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(wr_entry),
        .i_re   (ram_re),
        .i_raddr(r_rd_idx[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    // Sequencer, slot activity and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ev_valid  <= 1'b0;
            r_busy      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_op       <= s_axis_tuser;
                        r_term     <= s_axis_tdata[31:0];
                        r_off      <= s_axis_tdata[63:32];
                        r_len      <= s_axis_tdata[94:64];
                        r_now      <= s_axis_tdata[156:95];
                        r_invalid  <= in_invalid;
                        r_supp     <= 1'b0;
                        r_pick_ok  <= 1'b0;
                        r_changed  <= '0;
                        r_rd_idx   <= '0;
                        r_ev_valid <= 1'b0;
                        if (s_axis_tuser == OP_NAK) begin
                            r_state <= in_invalid ? S_FIN : S_SCAN;
                        end else begin
                            r_state <= (r_busy == 6'd0) ? S_SUM : S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (adv) begin
                        r_ev_valid <= rd_issue;
                        if (rd_issue) begin
                            r_ev_idx <= r_rd_idx[AW-1:0];
                            r_rd_idx <= r_rd_idx + CW'(1);
                        end
                    end
                    if (r_ev_valid) begin
                        if (r_op == OP_NAK) begin
                            // Take the first free slot; unicast reuses its active slot.
                            if (!ev_active) begin
                                if (!r_pick_ok) begin
                                    r_pick    <= r_ev_idx;
                                    r_pick_ok <= 1'b1;
                                end
                            end else if (ev_match) begin
                                r_supp <= 1'b1;
                            end else if (!r_group) begin
                                r_pick    <= r_ev_idx;
                                r_pick_ok <= 1'b1;
                            end
                        end else if (ev_tick_resend) begin
                            if (out_free) begin
                                r_out_valid <= 1'b1;
                                r_out_kind  <= KIND_RESEND;
                                r_out_term  <= rd_entry.term;
                                r_out_off   <= rd_entry.offset;
                                r_out_len   <= rd_entry.length;
                                r_out_cnt   <= '0;
                                r_out_last  <= 1'b0;
                                r_changed   <= r_changed + 6'd1;
                            end
                        end else if (ev_tick_free) begin
                            r_valid[r_ev_idx] <= 1'b0;
                            if (r_busy != 6'd0) begin
                                r_busy <= r_busy - 6'd1;
                            end
                            r_changed <= r_changed + 6'd1;
                        end
                    end
                    if (scan_done) begin
                        r_state <= (r_op == OP_NAK) ? S_FIN : S_SUM;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= fin_kind;
                        r_out_cnt   <= '0;
                        r_out_last  <= 1'b1;
                        if (fin_kind == KIND_RESEND) begin
                            r_out_term <= r_term;
                            r_out_off  <= r_off;
                            r_out_len  <= r_len;
                        end else begin
                            r_out_term <= '0;
                            r_out_off  <= '0;
                            r_out_len  <= '0;
                        end
                        if (fin_write) begin
                            r_valid[r_pick] <= 1'b1;
                            if (!r_valid[r_pick]) begin
                                r_busy <= r_busy + 6'd1;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_SUM: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_SUMMARY;
                        r_out_term  <= '0;
                        r_out_off   <= '0;
                        r_out_len   <= '0;
                        r_out_cnt   <= r_changed;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Port drive.
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {3'b0, r_out_cnt, r_out_len, r_out_off, r_out_term};

    // The busy count always equals the number of active slots.
    `NRS_ASSERT_SAME(a_busy_count, 1'b1, $countones(r_valid) == 32'(r_busy), "busy count off")
    // Slot writes stay within the slots in use.
    `NRS_ASSERT_SAME(a_write_range, ram_we, CW'(ram_waddr) < slots_used, "slot write range")
    // Only tick resends are results that are not the last of their item.
    `NRS_ASSERT_SAME(a_nonlast, r_out_valid && !r_out_last, r_out_kind == KIND_RESEND, "tlast")
    // An accepted item always starts work, so the block is busy in the next cycle.
    `NRS_ASSERT_NEXT(a_accept_start, in_accept, r_state != S_IDLE && !r_ev_valid, "no start")

endmodule

>>> verif/tb_nak_retransmit_scheduler.sv
// Self-checking testbench for the NAK retransmit scheduler: directed table, then random phases.
// Depends on nrs_pkg and nak_retransmit_scheduler; results are checked against a slot-table model.
`timescale 1ns / 1ps

module tb_nak_retransmit_scheduler;
    import nrs_pkg::*;

    localparam int NUM_SLOTS = 16;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [61:0] NOW_MAX = 62'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [39:0] TIMEOUT_MAX = 40'hFF_FFFF_FFFF;

    // Slot states of the scheduling model.
    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_DELAYED = 2'd1,
        SLOT_LINGER  = 2'd2
    } t_slot_state;

    // One expected result item.
    typedef struct {
        t_kind       kind;
        logic [31:0] term;
        logic [31:0] off;
        logic [30:0] len;
        logic [5:0]  cnt;
        logic        last;
    } t_result;

    // One row of the directed table: an input item or a register write.
    typedef struct {
        bit          is_cfg;
        logic        op;
        logic [31:0] term;
        logic [31:0] off;
        logic [30:0] len;
        logic [61:0] now;
        bit          typed;
        logic [2:0]  want_kind;
        logic [5:0]  want_cnt;
        logic [2:0]  idx;
        logic [39:0] val;
    } t_stim_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    logic [39:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    t_kind        m_axis_tuser;
    logic         m_axis_tlast;

    // Model copy of the registers.
    logic [39:0] cfg_delay;
    logic [39:0] cfg_linger;
    logic        cfg_group;
    logic [5:0]  cfg_active;
    logic [30:0] cfg_term_len;

    // Model copy of the slot table.
    t_slot_state slot_state [NUM_SLOTS];
    logic [31:0] slot_term [NUM_SLOTS];
    logic [31:0] slot_off [NUM_SLOTS];
    logic [30:0] slot_len [NUM_SLOTS];
    logic [63:0] slot_exp [NUM_SLOTS];
    logic [5:0]  busy_slots;

    t_result     pending_results [$];
    t_stim_row   dir_rows [$];
    int          err_count;
    int          hold_requests;
    bit          idle_on;
    logic [61:0] clock_ns;

    nak_retransmit_scheduler #(
        .MAX_SLOTS(NUM_SLOTS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock, 20 ns period.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic t_stim_row nak_row(input logic [31:0] term, input logic [31:0] off,
                                          input logic [30:0] len, input logic [61:0] now,
                                          input t_kind want);
        t_stim_row r;
        r = '{default: '0};
        r.op = OP_NAK;
        r.term = term;
        r.off = off;
        r.len = len;
        r.now = now;
        r.typed = 1'b1;
        r.want_kind = want;
        return r;
    endfunction

    function automatic t_stim_row tick_row(input logic [61:0] now, input bit typed,
                                           input logic [5:0] cnt);
        t_stim_row r;
        r = '{default: '0};
        r.op = OP_TICK;
        r.now = now;
        r.typed = typed;
        r.want_kind = KIND_SUMMARY;
        r.want_cnt = cnt;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [2:0] idx, input logic [39:0] val);
        t_stim_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            err_count++;
        end
    endfunction

    task automatic push_result(input t_kind kind, input logic [31:0] term,
                               input logic [31:0] off, input logic [30:0] len,
                               input logic [5:0] cnt, input logic last);
        t_result r;
        r.kind = kind;
        r.term = term;
        r.off = off;
        r.len = len;
        r.cnt = cnt;
        r.last = last;
        pending_results.push_back(r);
    endtask

    // Scheduling model: updates the slot table for one item and, when record is set,
    // queues the results that item causes.
    task automatic predict_schedule(input logic op, input logic [31:0] term,
                                    input logic [31:0] off, input logic [30:0] len,
                                    input logic [61:0] now, input bit record);
        int          n;
        int          pick;
        logic [5:0]  changed;
        longint      offs;
        longint      lim;
        logic [63:0] now64;
        n = 1;
        if (cfg_group) begin
            n = cfg_active;
            if (n < 1) n = 1;
            if (n > NUM_SLOTS) n = NUM_SLOTS;
        end
        now64 = {2'b00, now};
        if (op == OP_NAK) begin
            offs = longint'($signed(off));
            lim = longint'(cfg_term_len) - 32;
            pick = -1;
            if (offs < 0 || offs > lim) begin
                if (record) push_result(KIND_INVALID, 0, 0, 0, 0, 1'b1);
                return;
            end
            for (int i = 0; i < n; i++) begin
                if (slot_state[i] == SLOT_FREE) begin
                    if (pick < 0) pick = i;
                end else begin
                    if (slot_term[i] == term && longint'($signed(slot_off[i])) <= offs &&
                        offs < longint'($signed(slot_off[i])) + longint'(slot_len[i])) begin
                        if (record) push_result(KIND_SUPPRESSED, 0, 0, 0, 0, 1'b1);
                        return;
                    end
                    // Unicast mode reuses the single slot when nothing overlaps.
                    if (!cfg_group) pick = i;
                end
            end
            if (pick < 0) begin
                if (record) push_result(KIND_OVERFLOW, 0, 0, 0, 0, 1'b1);
                return;
            end
            if (slot_state[pick] == SLOT_FREE) busy_slots = busy_slots + 6'd1;
            slot_term[pick] = term;
            slot_off[pick] = off;
            slot_len[pick] = len;
            if (cfg_delay == '0) begin
                slot_state[pick] = SLOT_LINGER;
                slot_exp[pick] = now64 + {24'd0, cfg_linger};
                if (record) push_result(KIND_RESEND, term, off, len, 0, 1'b1);
            end else begin
                slot_state[pick] = SLOT_DELAYED;
                slot_exp[pick] = now64 + {24'd0, cfg_delay};
                if (record) push_result(KIND_DELAYED, 0, 0, 0, 0, 1'b1);
            end
        end else begin
            changed = '0;
            if (busy_slots != '0) begin
                for (int i = 0; i < n; i++) begin
                    if (slot_state[i] == SLOT_DELAYED && now64 > slot_exp[i]) begin
                        if (record) push_result(KIND_RESEND, slot_term[i], slot_off[i],
                                                slot_len[i], 0, 1'b0);
                        slot_state[i] = SLOT_LINGER;
                        slot_exp[i] = now64 + {24'd0, cfg_linger};
                        changed++;
                    end else if (slot_state[i] == SLOT_LINGER && now64 > slot_exp[i]) begin
                        slot_state[i] = SLOT_FREE;
                        if (busy_slots != '0) busy_slots = busy_slots - 6'd1;
                        changed++;
                    end
                end
            end
            if (record) push_result(KIND_SUMMARY, 0, 0, 0, changed, 1'b1);
        end
    endtask

    // Offers one item, with an optional idle burst first, and books its results.
    // Called and returns at a falling edge; tvalid stays high for a following item.
    task automatic send_item(input logic op, input logic [31:0] term, input logic [31:0] off,
                             input logic [30:0] len, input logic [61:0] now, input bit typed,
                             input t_kind want_kind, input logic [5:0] want_cnt);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {3'b000, now, len, off, term};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_schedule(op, term, off, len, now, !typed);
        if (typed) begin
            push_result(want_kind, (want_kind == KIND_RESEND) ? term : 32'd0,
                        (want_kind == KIND_RESEND) ? off : 32'd0,
                        (want_kind == KIND_RESEND) ? len : 31'd0, want_cnt, 1'b1);
        end
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every booked result has come, plus the block's latency.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Writes one register and mirrors it into the model.
    task automatic cfg_write(input logic [2:0] idx, input logic [39:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_DELAY:    cfg_delay = value;
            CFG_LINGER:   cfg_linger = value;
            CFG_GROUP:    cfg_group = value[0];
            CFG_ACTIVE:   cfg_active = value[5:0];
            CFG_TERM_LEN: cfg_term_len = value[30:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [39:0] delay, input logic [39:0] linger,
                            input logic grp, input logic [5:0] slots, input logic [30:0] tlen);
        wait_idle();
        cfg_write(CFG_DELAY, delay);
        cfg_write(CFG_LINGER, linger);
        cfg_write(CFG_GROUP, {39'd0, grp});
        cfg_write(CFG_ACTIVE, {34'd0, slots});
        cfg_write(CFG_TERM_LEN, {9'd0, tlen});
    endtask

    // Random items on a mostly rising clock: NAKs clustered on a few terms and
    // offsets so that they overlap, ticks, and a few out-of-range values.
    task automatic run_phase(input int items, input int hold_at, input int pause_at);
        logic [31:0] term;
        logic [31:0] off;
        logic [30:0] len;
        int          pick;
        for (int j = 0; j < items; j++) begin
            if (j == hold_at) hold_requests++;
            if (j == pause_at) wait_idle();
            clock_ns = clock_ns + $urandom_range(0, 120);
            if ($urandom_range(0, 9) == 0) clock_ns = clock_ns + $urandom_range(0, 3000);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                term = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
                case ($urandom_range(0, 9))
                    0: off = $urandom;
                    1: off = cfg_term_len - 33 + $urandom_range(0, 2);
                    default: off = $urandom_range(0, 2048);
                endcase
                len = ($urandom_range(0, 6) == 0) ? 31'($urandom_range(0, 1 << 30))
                                                 : 31'($urandom_range(0, 600));
                send_item(OP_NAK, term, off, len, clock_ns, 1'b0, KIND_SUMMARY, '0);
            end else if (pick < 95) begin
                // Unused fields carry noise on ticks.
                send_item(OP_TICK, $urandom, $urandom, 31'($urandom), clock_ns, 1'b0,
                          KIND_SUMMARY, '0);
            end else begin
                send_item(OP_TICK, '0, '0, '0, 62'({$urandom, $urandom}), 1'b0,
                          KIND_SUMMARY, '0);
            end
        end
    endtask

    // Result checker: every accepted result is matched against the oldest booking.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result_kind: expected no result, got %0d", m_axis_tuser);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", want.kind, m_axis_tuser);
                check_field("resend_term", want.term, m_axis_tdata[31:0]);
                check_field("resend_offset", want.off, m_axis_tdata[63:32]);
                check_field("resend_length", want.len, m_axis_tdata[94:64]);
                check_field("changed_count", want.cnt, m_axis_tdata[100:95]);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    // Receiver: random back-pressure bursts and, on request, one long hold-off.
    initial begin
        int hold_left;
        int idle_left;
        int holds_seen;
        hold_left = 0;
        idle_left = 0;
        holds_seen = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                idle_left = $urandom_range(0, 18);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        int cyc;
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge i_clk);
        $display("tb_nak_retransmit_scheduler: FAIL");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, drain and verdict.
    initial begin
        t_stim_row row;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_NAK;
        err_count = 0;
        hold_requests = 0;
        idle_on = 1'b1;
        clock_ns = '0;
        cfg_delay = '0;
        cfg_linger = '0;
        cfg_group = 1'b0;
        cfg_active = 6'd1;
        cfg_term_len = 31'd65536;
        busy_slots = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_state[i] = SLOT_FREE;
            slot_term[i] = '0;
            slot_off[i] = '0;
            slot_len[i] = '0;
            slot_exp[i] = '0;
        end

        // Unicast defaults after reset: range checks, reuse of the one slot, lingering.
        dir_rows.push_back(tick_row(62'd0, 1'b1, 6'd0));
        dir_rows.push_back(nak_row(32'd1, 32'hFFFF_FFFF, 31'd16, 62'd0, KIND_INVALID));
        dir_rows.push_back(nak_row(32'h8000_0000, 32'h8000_0000, 31'h4000_0000, 62'd0,
                                   KIND_INVALID));
        dir_rows.push_back(nak_row(32'd2, 32'd65505, 31'd16, 62'd0, KIND_INVALID));
        dir_rows.push_back(nak_row(32'h7FFF_FFFF, 32'd65504, 31'h4000_0000, 62'd100,
                                   KIND_RESEND));
        dir_rows.push_back(nak_row(32'h7FFF_FFFF, 32'd65504, 31'd8, 62'd100, KIND_SUPPRESSED));
        dir_rows.push_back(nak_row(32'h8000_0000, 32'd0, 31'd0, 62'd100, KIND_RESEND));
        dir_rows.push_back(nak_row(32'h8000_0000, 32'd0, 31'd4, 62'd100, KIND_RESEND));
        dir_rows.push_back(nak_row(32'h8000_0000, 32'd3, 31'd4, 62'd100, KIND_SUPPRESSED));
        dir_rows.push_back(tick_row(62'd100, 1'b0, 6'd0));
        dir_rows.push_back(tick_row(62'd101, 1'b0, 6'd0));
        dir_rows.push_back(tick_row(62'd102, 1'b1, 6'd0));
        // Group mode with two slots: delay, suppression inside a waiting range, overflow.
        dir_rows.push_back(cfg_row(CFG_GROUP, 40'd1));
        dir_rows.push_back(cfg_row(CFG_ACTIVE, 40'd2));
        dir_rows.push_back(cfg_row(CFG_DELAY, 40'd50));
        dir_rows.push_back(cfg_row(CFG_LINGER, 40'd30));
        dir_rows.push_back(nak_row(32'd5, 32'd1000, 31'd100, 62'd0, KIND_DELAYED));
        dir_rows.push_back(nak_row(32'd5, 32'd1099, 31'd1, 62'd5, KIND_SUPPRESSED));
        dir_rows.push_back(nak_row(32'd6, 32'd1000, 31'd10, 62'd10, KIND_DELAYED));
        dir_rows.push_back(nak_row(32'd7, 32'd0, 31'd10, 62'd10, KIND_OVERFLOW));
        dir_rows.push_back(tick_row(62'd55, 1'b0, 6'd0));
        dir_rows.push_back(tick_row(62'd100, 1'b0, 6'd0));
        // A slot count of zero means one; the second slot stays parked but busy.
        dir_rows.push_back(cfg_row(CFG_ACTIVE, 40'd0));
        dir_rows.push_back(nak_row(32'd8, 32'd0, 31'd64, 62'd100, KIND_DELAYED));
        dir_rows.push_back(tick_row(62'd1000, 1'b0, 6'd0));
        // A term shorter than the header makes every offset invalid.
        dir_rows.push_back(cfg_row(CFG_TERM_LEN, 40'd16));
        dir_rows.push_back(nak_row(32'd9, 32'd0, 31'd1, 62'd1000, KIND_INVALID));
        dir_rows.push_back(tick_row(62'd2000, 1'b0, 6'd0));
        // Largest term, timeouts and time: the expiry runs past the time field.
        dir_rows.push_back(cfg_row(CFG_TERM_LEN, 40'h4000_0000));
        dir_rows.push_back(cfg_row(CFG_DELAY, TIMEOUT_MAX));
        dir_rows.push_back(cfg_row(CFG_LINGER, TIMEOUT_MAX));
        dir_rows.push_back(nak_row(32'd10, 32'h3FFF_FFE0, 31'd1, NOW_MAX, KIND_DELAYED));
        dir_rows.push_back(tick_row(NOW_MAX, 1'b1, 6'd0));
        dir_rows.push_back(cfg_row(CFG_DELAY, 40'd0));
        dir_rows.push_back(nak_row(32'd11, 32'd0, 31'd1, NOW_MAX, KIND_OVERFLOW));

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            if (row.is_cfg) begin
                wait_idle();
                cfg_write(row.idx, row.val);
            end else begin
                send_item(row.op, row.term, row.off, row.len, row.now, row.typed,
                          t_kind'(row.want_kind), row.want_cnt);
            end
        end

        // Random phases over several settings; the first one fills the block
        // behind a long receiver hold-off, the second pauses the sender until drained.
        clock_ns = 62'd10000;
        set_regs(40'd200, 40'd300, 1'b1, 6'd16, 31'd65536);
        run_phase(26, 8, -1);
        set_regs(40'd0, 40'd500, 1'b1, 6'd63, 31'd1048576);
        run_phase(26, -1, 15);
        set_regs(40'd100, 40'd100, 1'b0, 6'd5, 31'd65536);
        run_phase(26, -1, -1);
        set_regs(40'd1000, 40'd0, 1'b1, 6'd4, 31'h4000_0000);
        run_phase(26, -1, -1);
        set_regs(40'($urandom_range(1, 400)), 40'($urandom_range(0, 600)), 1'b1,
                 6'($urandom_range(1, 16)), 31'($urandom_range(65536, 1 << 30)));
        run_phase(26, -1, -1);
        // Final stretch runs at full rate on both sides.
        idle_on = 1'b0;
        set_regs(40'd0, 40'd50, 1'b0, 6'd1, 31'd65536);
        run_phase(26, -1, -1);

        wait_idle();
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("tb_nak_retransmit_scheduler: PASS");
        end else begin
            $display("tb_nak_retransmit_scheduler: FAIL");
        end
        $finish;
    end

endmodule
